// File: hw/rtl/dts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dts_pkg
// Shared types and constants of the delimiter token splitter.
// ----------------------------------------------------------------------------
package dts_pkg;

  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned LEN_W      = 4;

  localparam logic [CFG_IDX_W-1:0] REG_DELIM_BYTES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DELIM_LEN   = 1'b1;

  typedef enum logic {
    KIND_BYTE = 1'b0,
    KIND_MARK = 1'b1
  } res_kind_e;

  // one queued input word
  typedef struct packed {
    logic       eob;
    logic [7:0] data;
  } item_t;

  // engine to output stage: one step of work
  typedef struct packed {
    logic       emit;
    logic       done;
    res_kind_e  kind;
    logic [7:0] data;
  } ev_t;

endpackage

// File: hw/rtl/delimiter_token_splitter.sv
`timescale 1ns / 1ps
// Path: a queued word's results pass the hold register and then the output register.
// Throughput: one word per cycle while the output takes results; the window engine
// holds the queue while it flushes the window at a buffer end, byte by byte.
// Reset: asynchronous, active low; clears the queue, window state and output,
// and sets the delimiter to zero with a length of one.
// ----------------------------------------------------------------------------
// delimiter_token_splitter
// Splits a byte stream into tokens around a configurable delimiter.
// ----------------------------------------------------------------------------
module delimiter_token_splitter #(
  parameter int unsigned MAX_DELIM_BYTES = 8,
  parameter int unsigned QUEUE_DEPTH     = 2
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [dts_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [dts_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,   // data_byte
  input  logic                             s_axis_tlast,   // end_of_buffer
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [7:0]                       m_axis_tdata,   // token_byte
  output logic                             m_axis_tlast,   // last_of_run
  output logic                             m_axis_tuser    // result_kind
);
  import dts_pkg::*;

  logic [CFG_DATA_W-1:0] delim_q;
  logic [LEN_W-1:0]      dlen_q;

  logic   q_vld;
  item_t  q_item;
  logic   q_pop;
  logic   p_free;
  ev_t    ev;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q <= '0;
      dlen_q  <= LEN_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_DELIM_BYTES: delim_q <= cfg_data_i;
        REG_DELIM_LEN:   dlen_q  <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  dts_front #(
    .Depth (QUEUE_DEPTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .pop_i         (q_pop),
    .vld_o         (q_vld),
    .item_o        (q_item)
  );

  dts_engine #(
    .MaxDelimBytes (MAX_DELIM_BYTES)
  ) u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .delim_i  (delim_q[8*MAX_DELIM_BYTES-1:0]),
    .dlen_i   (dlen_q),
    .q_vld_i  (q_vld),
    .q_item_i (q_item),
    .q_pop_o  (q_pop),
    .p_free_i (p_free),
    .ev_o     (ev)
  );

  dts_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ev_i          (ev),
    .p_free_o      (p_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// File: hw/rtl/dts_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dts_front
// Input side: accepts buffer words and queues them for the window engine.
// ----------------------------------------------------------------------------
module dts_front #(
  parameter int unsigned Depth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_axis_tvalid,
  output logic           s_axis_tready,
  input  logic [7:0]     s_axis_tdata,   // data_byte
  input  logic           s_axis_tlast,   // end_of_buffer
  input  logic           pop_i,
  output logic           vld_o,
  output dts_pkg::item_t item_o
);
  import dts_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  item_t          mem_q [Depth];
  logic [AW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           push;

  assign s_axis_tready = (cnt_q != CW'(Depth));
  assign push          = s_axis_tvalid & s_axis_tready;
  assign vld_o         = (cnt_q != '0);
  assign item_o        = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= '{eob: s_axis_tlast, data: s_axis_tdata};
    end
  end

endmodule

// File: hw/rtl/dts_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dts_engine
// Look-ahead window: appends a word, matches the delimiter, emits results.
// ----------------------------------------------------------------------------
module dts_engine #(
  parameter int unsigned MaxDelimBytes = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [8*MaxDelimBytes-1:0]      delim_i,
  input  logic [dts_pkg::LEN_W-1:0]       dlen_i,
  input  logic                            q_vld_i,
  input  dts_pkg::item_t                  q_item_i,
  output logic                            q_pop_o,
  input  logic                            p_free_i,
  output dts_pkg::ev_t                    ev_o
);
  import dts_pkg::*;

  localparam int unsigned WW = 8 * MaxDelimBytes;
  localparam int unsigned FW = $clog2(MaxDelimBytes + 1);

  logic [WW-1:0]  win_q, win_d;
  logic [FW-1:0]  fill_q, fill_d;
  logic           inside_q, inside_d;
  logic           busy_q;
  logic           eob_q;

  logic [WW-1:0]  ww;
  logic [FW-1:0]  wf;
  logic           weob;
  logic [FW-1:0]  len_eff;
  logic [MaxDelimBytes-1:0] eq;
  logic           match;
  logic           emit;
  res_kind_e      kind;
  logic [7:0]     data;
  logic           done;
  logic           active;
  logic           go;

  // clamp the length register to 1..MaxDelimBytes
  always_comb begin
    if (dlen_i == '0) begin
      len_eff = FW'(1);
    end else if (dlen_i > LEN_W'(MaxDelimBytes)) begin
      len_eff = FW'(MaxDelimBytes);
    end else begin
      len_eff = dlen_i[FW-1:0];
    end
  end

  // working window: held item, or the window with the next word appended
  always_comb begin
    if (busy_q) begin
      ww   = win_q;
      wf   = fill_q;
      weob = eob_q;
    end else begin
      ww   = (win_q & ~({{(WW-8){1'b0}}, 8'hFF} << {fill_q, 3'b000}))
           | ({{(WW-8){1'b0}}, q_item_i.data} << {fill_q, 3'b000});
      wf   = fill_q + FW'(1);
      weob = q_item_i.eob;
    end
  end

  always_comb begin
    for (int i = 0; i < MaxDelimBytes; i++) begin
      eq[i] = (ww[8*i +: 8] == delim_i[8*i +: 8]) || (FW'(i) >= len_eff);
    end
    match = &eq;
  end

  always_comb begin
    emit     = 1'b0;
    kind     = KIND_BYTE;
    data     = 8'h00;
    win_d    = ww;
    fill_d   = wf;
    inside_d = inside_q;
    if (wf >= len_eff) begin
      if (match) begin
        // drop the whole delimiter, close an open token
        win_d    = ww >> {len_eff, 3'b000};
        fill_d   = wf - len_eff;
        inside_d = 1'b0;
        if (inside_q) begin
          emit = 1'b1;
          kind = KIND_MARK;
        end
      end else begin
        emit     = 1'b1;
        data     = ww[7:0];
        win_d    = ww >> 8;
        fill_d   = wf - FW'(1);
        inside_d = 1'b1;
      end
    end else if (weob) begin
      // flush what is left, then close the token
      if (wf != '0) begin
        emit     = 1'b1;
        data     = ww[7:0];
        win_d    = ww >> 8;
        fill_d   = wf - FW'(1);
        inside_d = 1'b1;
      end else if (inside_q) begin
        emit     = 1'b1;
        kind     = KIND_MARK;
        inside_d = 1'b0;
      end
    end
    done = weob ? ((fill_d == '0) && !inside_d) : (fill_d < len_eff);
  end

  assign active  = busy_q | q_vld_i;
  assign go      = active & (~emit | p_free_i);
  assign q_pop_o = go & ~busy_q;

  always_comb begin
    ev_o.emit = go & emit;
    ev_o.done = go & done;
    ev_o.kind = kind;
    ev_o.data = data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      inside_q <= 1'b0;
      busy_q   <= 1'b0;
      eob_q    <= 1'b0;
    end else if (go) begin
      fill_q   <= fill_d;
      inside_q <= inside_d;
      busy_q   <= ~done;
      if (!busy_q) begin
        eob_q <= q_item_i.eob;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      win_q <= win_d;
    end
  end

endmodule

// File: hw/rtl/dts_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dts_emit
// Result hold and output register; marks the final result of each word.
// ----------------------------------------------------------------------------
module dts_emit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  dts_pkg::ev_t ev_i,
  output logic         p_free_o,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [7:0]   m_axis_tdata,   // token_byte
  output logic         m_axis_tlast,   // last_of_run
  output logic         m_axis_tuser    // result_kind
);
  import dts_pkg::*;

  logic       p_vld_q;
  logic       p_last_q;
  res_kind_e  p_kind_q;
  logic [7:0] p_data_q;

  logic       o_vld_q;
  logic       o_last_q;
  res_kind_e  o_kind_q;
  logic [7:0] o_data_q;

  logic       out_free;
  logic       p_move;

  assign out_free = ~o_vld_q | m_axis_tready;
  assign p_free_o = ~p_vld_q | out_free;
  // a held result leaves once it is known final or a newer one displaces it
  assign p_move   = p_vld_q & out_free & (p_last_q | ev_i.emit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q  <= 1'b0;
      p_last_q <= 1'b0;
      o_vld_q  <= 1'b0;
      o_last_q <= 1'b0;
    end else begin
      if (ev_i.emit) begin
        p_vld_q  <= 1'b1;
        p_last_q <= ev_i.done;
      end else if (p_move) begin
        p_vld_q  <= 1'b0;
      end else if (ev_i.done && p_vld_q) begin
        p_last_q <= 1'b1;
      end
      if (p_move) begin
        o_vld_q  <= 1'b1;
        o_last_q <= p_last_q;
      end else if (m_axis_tready) begin
        o_vld_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ev_i.emit) begin
      p_kind_q <= ev_i.kind;
      p_data_q <= ev_i.data;
    end
    if (p_move) begin
      o_kind_q <= p_kind_q;
      o_data_q <= p_data_q;
    end
  end

  assign m_axis_tvalid = o_vld_q;
  assign m_axis_tdata  = o_data_q;
  assign m_axis_tlast  = o_last_q;
  assign m_axis_tuser  = o_kind_q;

endmodule
